FILE: hw/rtl/ttacc_pkg.sv
package ttacc_pkg;

  localparam int ChanW   = 8;
  localparam int SelW    = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 12;
  localparam int ProdW   = 18;
  localparam int MagW    = 16;

  localparam logic [ChanW-1:0] FullScale = 8'd255;
  localparam logic [ChanW-1:0] HalfStep  = 8'd127;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COLOR_MODE   = 3'd0,
    CFG_ALPHA_FIRST  = 3'd1,
    CFG_ALPHA_SECOND = 3'd2,
    CFG_PRIM_ALPHA   = 3'd3,
    CFG_ENV_ALPHA    = 3'd4,
    CFG_LOD_FRACTION = 3'd5,
    CFG_MIX_FROM_ENV = 3'd6
  } cfg_index_t;

  typedef enum logic [SelW-1:0] {
    ASEL_COMBINED = 3'd0,
    ASEL_TEX_A    = 3'd1,
    ASEL_TEX_B    = 3'd2,
    ASEL_PRIM     = 3'd3,
    ASEL_ONE      = 3'd4,
    ASEL_ENV      = 3'd5,
    ASEL_ONE_ALT  = 3'd6,
    ASEL_ZERO     = 3'd7
  } alpha_sel_t;

  // Operand mux shared by the a, b and d inputs of both alpha cycles.
  function automatic logic [ChanW-1:0] alpha_operand(
    input logic [SelW-1:0]  sel,
    input logic [ChanW-1:0] comb,
    input logic [ChanW-1:0] tex_a,
    input logic [ChanW-1:0] tex_b,
    input logic [ChanW-1:0] prim,
    input logic [ChanW-1:0] env
  );
    logic [ChanW-1:0] res;
    unique case (alpha_sel_t'(sel))
      ASEL_COMBINED: res = comb;
      ASEL_TEX_A:    res = tex_a;
      ASEL_TEX_B:    res = tex_b;
      ASEL_PRIM:     res = prim;
      ASEL_ONE:      res = FullScale;
      ASEL_ENV:      res = env;
      ASEL_ONE_ALT:  res = FullScale;
      ASEL_ZERO:     res = '0;
      default:       res = '0;
    endcase
    return res;
  endfunction

  // The c input takes the LOD fraction where a, b and d would take the
  // combined value or the alternate full-scale constant.
  function automatic logic [ChanW-1:0] alpha_scale(
    input logic [SelW-1:0]  sel,
    input logic [ChanW-1:0] comb,
    input logic [ChanW-1:0] tex_a,
    input logic [ChanW-1:0] tex_b,
    input logic [ChanW-1:0] prim,
    input logic [ChanW-1:0] env,
    input logic [ChanW-1:0] lod
  );
    logic [ChanW-1:0] res;
    if (sel == ASEL_COMBINED || sel == ASEL_ONE_ALT) begin
      res = lod;
    end else begin
      res = alpha_operand(sel, comb, tex_a, tex_b, prim, env);
    end
    return res;
  endfunction

  // Exact x / 255 for any x below 65280, without a divider.
  function automatic logic [ChanW-1:0] div255(input logic [MagW-1:0] x);
    logic [MagW:0] tmp;
    tmp = {1'b0, x} + {{MagW{1'b0}}, 1'b1} + {9'd0, x[MagW-1:8]};
    return tmp[MagW-1:8];
  endfunction

  // Signed product to rounded magnitude quotient: half away from zero.
  function automatic logic [ChanW-1:0] alpha_quot(input logic signed [ProdW-1:0] prod);
    logic [ProdW-1:0] mag;
    logic [MagW:0]    sum;
    mag = prod[ProdW-1] ? (~prod + 1'b1) : prod;
    sum = {1'b0, mag[MagW-1:0]} + {9'd0, HalfStep};
    return div255(sum[MagW-1:0]);
  endfunction

  // d plus or minus the quotient, clamped to 0..255.
  function automatic logic [ChanW-1:0] alpha_finish(
    input logic             neg,
    input logic [ChanW-1:0] quot,
    input logic [ChanW-1:0] d
  );
    logic signed [ChanW+1:0] v;
    logic [ChanW-1:0] res;
    if (neg) begin
      v = $signed({2'b00, d}) - $signed({2'b00, quot});
    end else begin
      v = $signed({2'b00, d}) + $signed({2'b00, quot});
    end
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({2'b00, FullScale})) begin
      res = FullScale;
    end else begin
      res = v[ChanW-1:0];
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/two_texture_alpha_color_combiner_top.sv
// Two-texture color and alpha combiner.
// Input channel: one beat carries an RGBA texel from each of two textures
// (in_valid / in_stall). Output channel: one beat carries the combined RGBA
// pixel (out_valid / out_stall). Every input beat yields exactly one output.
// Configuration is a write port (cfg_write, cfg_index, cfg_data) and should
// only be written while no pixel is in flight.
// The datapath is a six-stage pipeline: multiply, divide, first alpha clamp,
// second alpha multiply, divide, second alpha clamp into the output register.
// out_valid is the valid bit of the output register, which a beat reaches
// through the stage registers in order, and one pixel is taken every cycle
// when the receiver does not stall.
// Each stage holds its own valid bit, so a stall at the output backs up
// stage by stage; bubbles are squeezed out before in_stall is raised, and
// nothing is dropped or repeated.
// Synchronous reset empties the pipeline and clears all configuration
// registers to zero.
module two_texture_alpha_color_combiner_top
  import ttacc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgW-1:0]      cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ChanW-1:0]     tex0_red,
  input  logic [ChanW-1:0]     tex0_green,
  input  logic [ChanW-1:0]     tex0_blue,
  input  logic [ChanW-1:0]     tex0_alpha,
  input  logic [ChanW-1:0]     tex1_red,
  input  logic [ChanW-1:0]     tex1_green,
  input  logic [ChanW-1:0]     tex1_blue,
  input  logic [ChanW-1:0]     tex1_alpha,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ChanW-1:0]     out_red,
  output logic [ChanW-1:0]     out_green,
  output logic [ChanW-1:0]     out_blue,
  output logic [ChanW-1:0]     out_alpha
);

  localparam int Stages = 6;

  logic [1:0]       color_mode;
  logic [CfgW-1:0]  alpha_eq_first;
  logic [CfgW-1:0]  alpha_eq_second;
  logic [ChanW-1:0] prim_alpha;
  logic [ChanW-1:0] env_alpha;
  logic [ChanW-1:0] lod_fraction;
  logic             mix_from_env;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode      <= '0;
      alpha_eq_first  <= '0;
      alpha_eq_second <= '0;
      prim_alpha      <= '0;
      env_alpha       <= '0;
      lod_fraction    <= '0;
      mix_from_env    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COLOR_MODE:   color_mode      <= cfg_data[1:0];
        CFG_ALPHA_FIRST:  alpha_eq_first  <= cfg_data;
        CFG_ALPHA_SECOND: alpha_eq_second <= cfg_data;
        CFG_PRIM_ALPHA:   prim_alpha      <= cfg_data[ChanW-1:0];
        CFG_ENV_ALPHA:    env_alpha       <= cfg_data[ChanW-1:0];
        CFG_LOD_FRACTION: lod_fraction    <= cfg_data[ChanW-1:0];
        CFG_MIX_FROM_ENV: mix_from_env    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Per-stage valid bits and the ready chain from the output backwards.
  logic [Stages-1:0] vld;
  logic [Stages-1:0] rdy;
  logic [Stages-1:0] vld_in;

  always_comb begin
    rdy[Stages-1] = !vld[Stages-1] || !out_stall;
    for (int k = Stages - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    vld_in = {vld[Stages-2:0], in_valid};
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  logic [Stages-1:0] load;
  assign load = rdy & vld_in;

  // Stage 1: color products and first alpha product.
  logic [ChanW-1:0] t0c [3];
  logic [ChanW-1:0] t1c [3];
  assign t0c[0] = tex0_red;
  assign t0c[1] = tex0_green;
  assign t0c[2] = tex0_blue;
  assign t1c[0] = tex1_red;
  assign t1c[1] = tex1_green;
  assign t1c[2] = tex1_blue;

  logic [ChanW-1:0] factor;
  logic             blend;
  logic [MagW-1:0]  m0_next [3];
  logic [MagW-1:0]  m1_next [3];
  logic [ChanW-1:0] a1, b1, c1, d1;
  logic signed [ProdW-1:0] prod1_next;

  always_comb begin
    factor = mix_from_env ? env_alpha : lod_fraction;
    if (color_mode[1]) begin
      factor = ~factor;
    end
    blend = (color_mode != 2'd0);
    for (int i = 0; i < 3; i++) begin
      m0_next[i] = t0c[i] * (blend ? (FullScale - factor) : t1c[i]);
      m1_next[i] = blend ? (t1c[i] * factor) : '0;
    end
    a1 = alpha_operand(alpha_eq_first[2:0], '0, tex0_alpha, tex1_alpha,
                       prim_alpha, env_alpha);
    b1 = alpha_operand(alpha_eq_first[5:3], '0, tex0_alpha, tex1_alpha,
                       prim_alpha, env_alpha);
    c1 = alpha_scale(alpha_eq_first[8:6], '0, tex0_alpha, tex1_alpha,
                     prim_alpha, env_alpha, lod_fraction);
    d1 = alpha_operand(alpha_eq_first[11:9], '0, tex0_alpha, tex1_alpha,
                       prim_alpha, env_alpha);
    prod1_next = ($signed({1'b0, a1}) - $signed({1'b0, b1})) * $signed({1'b0, c1});
  end

  logic [MagW-1:0]         s1_m0 [3];
  logic [MagW-1:0]         s1_m1 [3];
  logic signed [ProdW-1:0] s1_prod;
  logic [ChanW-1:0]        s1_d;
  logic [ChanW-1:0]        s1_ta0;
  logic [ChanW-1:0]        s1_ta1;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_m0   <= m0_next;
      s1_m1   <= m1_next;
      s1_prod <= prod1_next;
      s1_d    <= d1;
      s1_ta0  <= tex0_alpha;
      s1_ta1  <= tex1_alpha;
    end
  end

  // Stage 2: color rounding divide and first alpha quotient.
  logic [MagW:0]    csum [3];
  logic [ChanW-1:0] color2_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csum[i] = {1'b0, s1_m0[i]} + {1'b0, s1_m1[i]} + {9'd0, HalfStep};
      color2_next[i] = div255(csum[i][MagW-1:0]);
    end
  end

  logic [ChanW-1:0] s2_color [3];
  logic [ChanW-1:0] s2_quot;
  logic             s2_neg;
  logic [ChanW-1:0] s2_d;
  logic [ChanW-1:0] s2_ta0;
  logic [ChanW-1:0] s2_ta1;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_color <= color2_next;
      s2_quot  <= alpha_quot(s1_prod);
      s2_neg   <= s1_prod[ProdW-1];
      s2_d     <= s1_d;
      s2_ta0   <= s1_ta0;
      s2_ta1   <= s1_ta1;
    end
  end

  // Stage 3: first alpha result.
  logic [ChanW-1:0] s3_color [3];
  logic [ChanW-1:0] s3_first;
  logic [ChanW-1:0] s3_ta0;
  logic [ChanW-1:0] s3_ta1;

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s3_color <= s2_color;
      s3_first <= alpha_finish(s2_neg, s2_quot, s2_d);
      s3_ta0   <= s2_ta0;
      s3_ta1   <= s2_ta1;
    end
  end

  // Stage 4: second alpha product; the texel alphas swap roles here.
  logic [ChanW-1:0] a2, b2, c2, d2;
  logic signed [ProdW-1:0] prod2_next;

  always_comb begin
    a2 = alpha_operand(alpha_eq_second[2:0], s3_first, s3_ta1, s3_ta0,
                       prim_alpha, env_alpha);
    b2 = alpha_operand(alpha_eq_second[5:3], s3_first, s3_ta1, s3_ta0,
                       prim_alpha, env_alpha);
    c2 = alpha_scale(alpha_eq_second[8:6], s3_first, s3_ta1, s3_ta0,
                     prim_alpha, env_alpha, lod_fraction);
    d2 = alpha_operand(alpha_eq_second[11:9], s3_first, s3_ta1, s3_ta0,
                       prim_alpha, env_alpha);
    prod2_next = ($signed({1'b0, a2}) - $signed({1'b0, b2})) * $signed({1'b0, c2});
  end

  logic [ChanW-1:0]        s4_color [3];
  logic signed [ProdW-1:0] s4_prod;
  logic [ChanW-1:0]        s4_d;

  always_ff @(posedge clk) begin
    if (load[3]) begin
      s4_color <= s3_color;
      s4_prod  <= prod2_next;
      s4_d     <= d2;
    end
  end

  // Stage 5: second alpha quotient.
  logic [ChanW-1:0] s5_color [3];
  logic [ChanW-1:0] s5_quot;
  logic             s5_neg;
  logic [ChanW-1:0] s5_d;

  always_ff @(posedge clk) begin
    if (load[4]) begin
      s5_color <= s4_color;
      s5_quot  <= alpha_quot(s4_prod);
      s5_neg   <= s4_prod[ProdW-1];
      s5_d     <= s4_d;
    end
  end

  // Stage 6: output register.
  logic [ChanW-1:0] s6_color [3];
  logic [ChanW-1:0] s6_alpha;

  always_ff @(posedge clk) begin
    if (load[5]) begin
      s6_color <= s5_color;
      s6_alpha <= alpha_finish(s5_neg, s5_quot, s5_d);
    end
  end

  assign out_red   = s6_color[0];
  assign out_green = s6_color[1];
  assign out_blue  = s6_color[2];
  assign out_alpha = s6_alpha;

endmodule

FILE: tb/sv/two_texture_alpha_color_combiner_top_tb.sv
module two_texture_alpha_color_combiner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttacc_pkg::*;

  localparam logic [1:0] ModeMultiply    = 2'd0;
  localparam logic [1:0] ModeBlend       = 2'd1;
  localparam logic [1:0] ModeBlendInv    = 2'd2;
  localparam logic [1:0] ModeBlendInvAlt = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgIndexSpare = 3'd7;
  localparam int NumRegs       = int'(CFG_MIX_FROM_ENV) + 1;
  localparam int DrainCycles   = 8;
  localparam int IdleLimit     = 1000;
  localparam int RandomPixels  = 850;
  localparam int MaxReported   = 10;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [1:0]       color_mode;
    logic [CfgW-1:0]  eq_first;
    logic [CfgW-1:0]  eq_second;
    logic [ChanW-1:0] prim;
    logic [ChanW-1:0] env;
    logic [ChanW-1:0] lod;
    logic             mix_env;
  } combiner_regs_t;

  typedef logic [CfgW-1:0] reg_image_t [NumRegs];

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]  cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ChanW-1:0] tex0_red = '0;
  logic [ChanW-1:0] tex0_green = '0;
  logic [ChanW-1:0] tex0_blue = '0;
  logic [ChanW-1:0] tex0_alpha = '0;
  logic [ChanW-1:0] tex1_red = '0;
  logic [ChanW-1:0] tex1_green = '0;
  logic [ChanW-1:0] tex1_blue = '0;
  logic [ChanW-1:0] tex1_alpha = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ChanW-1:0] out_red;
  logic [ChanW-1:0] out_green;
  logic [ChanW-1:0] out_blue;
  logic [ChanW-1:0] out_alpha;

  combiner_regs_t regs = '0;
  rgba_t          expected_pixels [$];
  int             pixels_sent = 0;
  int             pixels_checked = 0;
  int             settings_applied = 0;
  int             mismatches = 0;
  int             burst_left = 0;
  int             idle_cycles = 0;
  stall_kind_t    stall_kind = STALL_NONE;
  int             stall_left = 0;
  int             stall_tick = 0;

  two_texture_alpha_color_combiner_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .tex0_red   (tex0_red),
    .tex0_green (tex0_green),
    .tex0_blue  (tex0_blue),
    .tex0_alpha (tex0_alpha),
    .tex1_red   (tex1_red),
    .tex1_green (tex1_green),
    .tex1_blue  (tex1_blue),
    .tex1_alpha (tex1_alpha),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int alpha_pick(input logic [SelW-1:0] code, input int ta, input int tb,
                                    input int comb);
    unique case (alpha_sel_t'(code))
      ASEL_COMBINED: return comb;
      ASEL_TEX_A:    return ta;
      ASEL_TEX_B:    return tb;
      ASEL_PRIM:     return int'(regs.prim);
      ASEL_ENV:      return int'(regs.env);
      ASEL_ZERO:     return 0;
      default:       return 255;
    endcase
  endfunction

  function automatic int alpha_pass(input logic [CfgW-1:0] eq, input int ta, input int tb,
                                    input int comb);
    logic [SelW-1:0] c_code;
    int scale;
    int prod;
    int sum;
    c_code = eq[8:6];
    // The scale slot reads the LOD fraction where the other slots would read
    // the combined value or the spare full-scale code.
    if (c_code == ASEL_COMBINED || c_code == ASEL_ONE_ALT) begin
      scale = int'(regs.lod);
    end else begin
      scale = alpha_pick(c_code, ta, tb, comb);
    end
    prod = (alpha_pick(eq[2:0], ta, tb, comb) - alpha_pick(eq[5:3], ta, tb, comb)) * scale;
    sum = (prod < 0 ? prod - 127 : prod + 127) / 255 + alpha_pick(eq[11:9], ta, tb, comb);
    if (sum < 0) begin
      sum = 0;
    end else if (sum > 255) begin
      sum = 255;
    end
    return sum;
  endfunction

  function automatic rgba_t combine_pixel(input rgba_t t0, input rgba_t t1);
    int src0 [3];
    int src1 [3];
    int chan [3];
    int factor;
    int first;
    rgba_t res;
    src0 = '{int'(t0.red), int'(t0.green), int'(t0.blue)};
    src1 = '{int'(t1.red), int'(t1.green), int'(t1.blue)};
    factor = regs.mix_env ? int'(regs.env) : int'(regs.lod);
    if (regs.color_mode[1]) begin
      factor = 255 - factor;
    end
    for (int i = 0; i < 3; i++) begin
      if (regs.color_mode == ModeMultiply) begin
        chan[i] = (src0[i] * src1[i] + 127) / 255;
      end else begin
        chan[i] = (src0[i] * (255 - factor) + src1[i] * factor + 127) / 255;
      end
    end
    res.red   = chan[0][ChanW-1:0];
    res.green = chan[1][ChanW-1:0];
    res.blue  = chan[2][ChanW-1:0];
    // The second pass sees the texel alphas swapped.
    first = alpha_pass(regs.eq_first, int'(t0.alpha), int'(t1.alpha), 0);
    first = alpha_pass(regs.eq_second, int'(t1.alpha), int'(t0.alpha), first);
    res.alpha = first[ChanW-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic logic [CfgW-1:0] alpha_eq(input alpha_sel_t a, input alpha_sel_t b,
                                               input alpha_sel_t c, input alpha_sel_t d);
    return {d, c, b, a};
  endfunction

  function automatic rgba_t texel(input int r, input int g, input int b, input int a);
    return {r[ChanW-1:0], g[ChanW-1:0], b[ChanW-1:0], a[ChanW-1:0]};
  endfunction

  function automatic logic [ChanW-1:0] edgy_byte();
    unique case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rgba_t random_texel();
    return {edgy_byte(), edgy_byte(), edgy_byte(), edgy_byte()};
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    unique case (idx)
      CFG_COLOR_MODE:   regs.color_mode = val[1:0];
      CFG_ALPHA_FIRST:  regs.eq_first   = val;
      CFG_ALPHA_SECOND: regs.eq_second  = val;
      CFG_PRIM_ALPHA:   regs.prim       = val[ChanW-1:0];
      CFG_ENV_ALPHA:    regs.env        = val[ChanW-1:0];
      CFG_LOD_FRACTION: regs.lod        = val[ChanW-1:0];
      CFG_MIX_FROM_ENV: regs.mix_env    = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input reg_image_t img);
    cfg_index_t idx;
    idx = idx.first();
    do begin
      write_reg(idx, img[idx]);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  // Sends one texel pair in bursts of random length with random gaps between.
  task automatic send_texels(input rgba_t t0, input rgba_t t1);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    tex0_red   <= t0.red;
    tex0_green <= t0.green;
    tex0_blue  <= t0.blue;
    tex0_alpha <= t0.alpha;
    tex1_red   <= t1.red;
    tex1_green <= t1.green;
    tex1_blue  <= t1.blue;
    tex1_alpha <= t1.alpha;
    do @(posedge clk); while (in_stall);
    expected_pixels.push_back(combine_pixel(t0, t1));
    pixels_sent++;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    send_texels(texel(0, 0, 0, 0), texel(0, 0, 0, 0));
    send_texels(texel(255, 255, 255, 255), texel(255, 255, 255, 255));
    drain_pipeline();
  endtask

  task automatic test_color_multiply();
    reg_image_t img;
    img = '{default: '0};
    img[CFG_COLOR_MODE]   = CfgW'(ModeMultiply);
    // Alpha becomes the product of the two texel alphas, passed straight through.
    img[CFG_ALPHA_FIRST]  = alpha_eq(ASEL_TEX_A, ASEL_ZERO, ASEL_TEX_B, ASEL_ZERO);
    img[CFG_ALPHA_SECOND] = alpha_eq(ASEL_COMBINED, ASEL_ZERO, ASEL_ONE, ASEL_ZERO);
    apply_settings(img);
    send_texels(texel(255, 255, 255, 255), texel(255, 0, 1, 128));
    send_texels(texel(128, 1, 0, 64), texel(128, 1, 255, 200));
    send_texels(texel(0, 0, 0, 0), texel(255, 255, 255, 255));
    send_texels(texel(85, 170, 3, 255), texel(3, 3, 170, 255));
    drain_pipeline();
  endtask

  task automatic test_color_blend();
    reg_image_t img;
    logic [1:0] blend_modes [3];
    blend_modes = '{ModeBlend, ModeBlendInv, ModeBlendInvAlt};
    img = '{default: '0};
    img[CFG_ENV_ALPHA] = CfgW'(255);
    foreach (blend_modes[m]) begin
      for (int mix = 0; mix < 2; mix++) begin
        img[CFG_COLOR_MODE]   = CfgW'(blend_modes[m]);
        img[CFG_MIX_FROM_ENV] = CfgW'(mix);
        img[CFG_LOD_FRACTION] = CfgW'((blend_modes[m] == ModeBlendInvAlt) ? 100 : 0);
        apply_settings(img);
        send_texels(texel(0, 255, 100, 17), texel(255, 0, 7, 230));
        drain_pipeline();
      end
    end
  endtask

  task automatic test_alpha_equations();
    reg_image_t img;
    img = '{default: '0};
    // The first cycle overflows past full scale and must clamp.
    img[CFG_ALPHA_FIRST]  = alpha_eq(ASEL_ONE, ASEL_ZERO, ASEL_ONE, ASEL_ONE);
    img[CFG_ALPHA_SECOND] = alpha_eq(ASEL_ZERO, ASEL_ZERO, ASEL_ZERO, ASEL_COMBINED);
    apply_settings(img);
    send_texels(texel(1, 2, 3, 4), texel(5, 6, 7, 8));
    drain_pipeline();
    // A small negative first-cycle product rounds away from zero, then the second sum clamps at zero.
    img[CFG_ALPHA_FIRST]  = alpha_eq(ASEL_ZERO, ASEL_PRIM, ASEL_COMBINED, ASEL_ENV);
    img[CFG_ALPHA_SECOND] = alpha_eq(ASEL_TEX_A, ASEL_TEX_B, ASEL_ONE_ALT, ASEL_COMBINED);
    img[CFG_PRIM_ALPHA]   = CfgW'(1);
    img[CFG_LOD_FRACTION] = CfgW'(128);
    img[CFG_ENV_ALPHA]    = CfgW'(10);
    apply_settings(img);
    send_texels(texel(9, 9, 9, 255), texel(9, 9, 9, 0));
    drain_pipeline();
    // Walk every selector code through every slot, over the two passes together.
    img[CFG_PRIM_ALPHA]   = CfgW'(77);
    img[CFG_ENV_ALPHA]    = CfgW'(200);
    img[CFG_LOD_FRACTION] = CfgW'(33);
    for (int k = 0; k < 8; k += 2) begin
      img[CFG_ALPHA_FIRST]  = alpha_eq(alpha_sel_t'(k), alpha_sel_t'(k + 1),
                                       alpha_sel_t'(k), alpha_sel_t'(k + 1));
      img[CFG_ALPHA_SECOND] = alpha_eq(alpha_sel_t'(k + 1), alpha_sel_t'(k),
                                       alpha_sel_t'(k + 1), alpha_sel_t'(k));
      apply_settings(img);
      send_texels(random_texel(), random_texel());
      drain_pipeline();
    end
  endtask

  task automatic test_spare_index();
    write_reg(CfgIndexSpare, '1);
    cfg_write <= 1'b0;
    send_texels(texel(200, 50, 255, 90), texel(30, 255, 0, 160));
    send_texels(random_texel(), random_texel());
    drain_pipeline();
  endtask

  task automatic test_random_traffic();
    reg_image_t img;
    int left;
    int phase;
    int run;
    left = RandomPixels;
    phase = 0;
    while (left > 0) begin
      // The first two settings are all ones and all zeros.
      foreach (img[i]) begin
        if (phase == 0) begin
          img[i] = '1;
        end else if (phase == 1) begin
          img[i] = '0;
        end else begin
          img[i] = CfgW'($urandom_range(0, (1 << CfgW) - 1));
        end
      end
      if (phase > 1) begin
        img[CFG_PRIM_ALPHA]   = CfgW'(edgy_byte());
        img[CFG_ENV_ALPHA]    = CfgW'(edgy_byte());
        img[CFG_LOD_FRACTION] = CfgW'(edgy_byte());
      end
      apply_settings(img);
      run = (left < 80) ? left : $urandom_range(20, 80);
      repeat (run) send_texels(random_texel(), random_texel());
      drain_pipeline();
      left -= run;
      phase++;
    end
  endtask

  // ---------------------------------------------------------------- output side

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind <= stall_kind_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    unique case (stall_kind)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
      default:     out_stall <= ((stall_tick % 7) < 3);
    endcase
  end

  always @(posedge clk) begin
    rgba_t got;
    rgba_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {out_red, out_green, out_blue, out_alpha};
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("Unexpected pixel %h %h %h %h with nothing outstanding",
                   got.red, got.green, got.blue, got.alpha);
        end
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.alpha !== want.alpha) begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("Pixel %0d mismatch: expected rgba %h %h %h %h, got %h %h %h %h",
                     pixels_checked, want.red, want.green, want.blue, want.alpha,
                     got.red, got.green, got.blue, got.alpha);
          end
        end
        pixels_checked++;
      end
    end
  end

  // A beat on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout after %0d idle cycles, %0d pixels outstanding",
               idle_cycles, expected_pixels.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_color_multiply();
    test_color_blend();
    test_alpha_equations();
    test_spare_index();
    test_random_traffic();
    $display("Checked %0d of %0d pixels under %0d register settings, %0d mismatches.",
             pixels_checked, pixels_sent, settings_applied, mismatches);
    $display("Covered multiply, all blend decodes, every alpha selector slot and clamping.");
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
